FILE: design/bsm_pkg.sv
`default_nettype none

package bsm_pkg;

    // Request operations
    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_KEY    = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    // Result target codes
    typedef enum logic [3:0] {
        TGT_FLOAT    = 4'd0,
        TGT_DATA     = 4'd1,
        TGT_MAIN     = 4'd2,
        TGT_AUX      = 4'd3,
        TGT_LC_MAIN1 = 4'd4,
        TGT_LC_MAIN2 = 4'd5,
        TGT_LC_AUX1  = 4'd6,
        TGT_LC_AUX2  = 4'd7,
        TGT_ROM      = 4'd8,
        TGT_SLOT_ROM = 4'd9,
        TGT_EXT_IO   = 4'd10,
        TGT_IGNORED  = 4'd11,
        TGT_EXP_OFF  = 4'd12
    } t_target;

    // Kind of answer from the soft-switch page
    typedef enum logic [1:0] {
        IO_FLOAT = 2'd0,
        IO_DATA  = 2'd1,
        IO_EXT   = 2'd2
    } t_io_kind;

    // Memory map flag bit positions
    localparam int unsigned MM_STORE80   = 0;
    localparam int unsigned MM_RAMRD     = 1;
    localparam int unsigned MM_RAMWRT    = 2;
    localparam int unsigned MM_INTCXROM  = 3;
    localparam int unsigned MM_ALTZP     = 4;
    localparam int unsigned MM_SLOTC3ROM = 5;

    // Display flag bit positions
    localparam int unsigned DF_TEXT    = 0;
    localparam int unsigned DF_MIXED   = 1;
    localparam int unsigned DF_PAGE2   = 2;
    localparam int unsigned DF_HIRES   = 3;
    localparam int unsigned DF_COL80   = 4;
    localparam int unsigned DF_ALTCHAR = 5;
    localparam int unsigned DF_DHIRES  = 6;

    // Address map constants
    localparam logic [15:0] IO_BASE   = 16'hC000;
    localparam logic [15:0] EXP_OFF   = 16'hCFFF;
    localparam logic [15:0] LC_BASE   = 16'hD000;
    localparam logic [15:0] LC_HIGH   = 16'hE000;
    localparam logic [7:0]  IO_PAGE   = 8'hC0;

    // Soft-switch state
    typedef struct packed {
        logic [7:0] keyboard_latch;
        logic [5:0] mm;
        logic [6:0] disp;
        logic [3:0] ann;
        logic       io_disable;
        logic       bank_two;
        logic       rd_en;
        logic       wr_en;
        logic       prewrite;
    } t_sw_state;

    // Answer of the soft-switch page for one request
    typedef struct packed {
        t_io_kind   kind;
        logic [7:0] val;
        logic       spk;
        logic       vid;
    } t_io_result;

    // Decoded bus result
    typedef struct packed {
        t_target     target;
        logic [15:0] bank_offset;
        logic [7:0]  read_data;
        logic        write_strobe;
        logic [7:0]  write_value;
        logic        speaker_toggle;
        logic        video_refresh;
    } t_result;

endpackage

`default_nettype wire

FILE: design/bank_switch_mmu.sv
// Bank-switching bus decoder with soft switches and language card. Each
// request on the slave stream is a bus read, a bus write or a keyboard latch
// load (tuser); it is decoded against the soft-switch state into a target
// store and byte offset, reported on the master stream with the display and
// annunciator flags as they stand after the access. Requests flow through an
// input register and a result register: one request per clock is taken while
// the master side keeps up. Stalling on the master side backs up through
// tready without losing or repeating any request. The RAM and ROM arrays and
// forwarded I/O live outside the block.
`default_nettype none

module bank_switch_mmu (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Request stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: address[15:0], write_data[23:16], key_code[31:24],
    //        vertical_blank[32], floating_value[40:33], zero pad[47:41]
    input  wire [47:0]  s_axis_tdata,
    // tuser: operation[1:0]
    input  wire [1:0]   s_axis_tuser,
    // Result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tdata: bank_offset[15:0], read_data[23:16], write_strobe[24],
    //        write_value[32:25], speaker_toggle[33], video_refresh[34],
    //        display_flags[41:35], annunciators[45:42], zero pad[47:46]
    output logic [47:0] m_axis_tdata,
    // tuser: target[3:0]
    output logic [3:0]  m_axis_tuser
);
    import bsm_pkg::*;

    // Input register
    logic        r_in_valid;
    logic [1:0]  r_operation;
    logic [15:0] r_address;
    logic [7:0]  r_write_data;
    logic [7:0]  r_key_code;
    logic        r_vertical_blank;
    logic [7:0]  r_floating_value;

    // Result register
    logic        r_out_valid;
    t_result     r_result;
    logic [6:0]  r_display_flags;
    logic [3:0]  r_annunciators;

    logic        fire;
    t_sw_state   state;
    t_io_result  io;
    t_result     result;
    logic [6:0]  disp_next;
    logic [3:0]  ann_next;

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    // Input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Input stage payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_operation      <= s_axis_tuser;
            r_address        <= s_axis_tdata[15:0];
            r_write_data     <= s_axis_tdata[23:16];
            r_key_code       <= s_axis_tdata[31:24];
            r_vertical_blank <= s_axis_tdata[32];
            r_floating_value <= s_axis_tdata[40:33];
        end
    end

    bsm_softswitch u_softswitch (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_operation      (r_operation),
        .i_address        (r_address),
        .i_key_code       (r_key_code),
        .i_vertical_blank (r_vertical_blank),
        .o_state          (state),
        .o_io             (io),
        .o_disp_next      (disp_next),
        .o_ann_next       (ann_next)
    );

    bsm_decode u_decode (
        .i_operation      (r_operation),
        .i_address        (r_address),
        .i_write_data     (r_write_data),
        .i_floating_value (r_floating_value),
        .i_state          (state),
        .i_io             (io),
        .o_result         (result)
    );

    // Result stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result stage payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result        <= result;
            r_display_flags <= disp_next;
            r_annunciators  <= ann_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_result.target;
    assign m_axis_tdata  = {2'b00,
                            r_annunciators,
                            r_display_flags,
                            r_result.video_refresh,
                            r_result.speaker_toggle,
                            r_result.write_value,
                            r_result.write_strobe,
                            r_result.read_data,
                            r_result.bank_offset};

endmodule

`default_nettype wire

FILE: design/bsm_softswitch.sv
`default_nettype none

module bsm_softswitch (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_fire,
    input  wire [1:0]            i_operation,
    input  wire [15:0]           i_address,
    input  wire [7:0]            i_key_code,
    input  wire                  i_vertical_blank,
    output bsm_pkg::t_sw_state   o_state,
    output bsm_pkg::t_io_result  o_io,
    output logic [6:0]           o_disp_next,
    output logic [3:0]           o_ann_next
);
    import bsm_pkg::*;

    t_sw_state  r_state;
    t_sw_state  n_state;
    t_io_result io;
    logic       io_hit;
    logic       wr;
    logic       on;
    logic [7:0] low;
    logic       stat;

    assign wr  = (i_operation == OP_WRITE);
    assign low = i_address[7:0];
    assign on  = low[0];
    assign io_hit = (i_operation == OP_READ || i_operation == OP_WRITE)
                    && (i_address[15:8] == IO_PAGE);

    // Status flag for C011-C01F
    always_comb begin
        case (low[3:0])
            4'h1:    stat = r_state.bank_two;
            4'h2:    stat = r_state.rd_en;
            4'h3:    stat = r_state.mm[MM_RAMRD];
            4'h4:    stat = r_state.mm[MM_RAMWRT];
            4'h5:    stat = r_state.mm[MM_INTCXROM];
            4'h6:    stat = r_state.mm[MM_ALTZP];
            4'h7:    stat = r_state.mm[MM_SLOTC3ROM];
            4'h8:    stat = r_state.mm[MM_STORE80];
            4'h9:    stat = i_vertical_blank;
            4'hA:    stat = r_state.disp[DF_TEXT];
            4'hB:    stat = r_state.disp[DF_MIXED];
            4'hC:    stat = r_state.disp[DF_PAGE2];
            4'hD:    stat = r_state.disp[DF_HIRES];
            4'hE:    stat = r_state.disp[DF_ALTCHAR];
            default: stat = r_state.disp[DF_COL80];
        endcase
    end

    // Soft-switch page decode and next state
    always_comb begin
        n_state = r_state;
        io.kind = IO_FLOAT;
        io.val  = 8'h00;
        io.spk  = 1'b0;
        io.vid  = 1'b0;

        if (i_operation == OP_KEY) begin
            n_state.keyboard_latch = i_key_code;
        end

        if (io_hit) begin
            if (low <= 8'h0F) begin
                if (wr) begin
                    if (low[3:1] < 3'd6) begin
                        n_state.mm[low[3:1]] = on;
                    end else if (low[3:1] == 3'd6) begin
                        n_state.disp[DF_COL80] = on;
                    end else begin
                        n_state.disp[DF_ALTCHAR] = on;
                    end
                end else if (low == 8'h00) begin
                    io.kind = IO_DATA;
                    io.val  = r_state.keyboard_latch;
                end
            end else if (low == 8'h10) begin
                // Keyboard strobe clear
                n_state.keyboard_latch[7] = 1'b0;
                io.kind = IO_DATA;
                io.val  = {1'b0, r_state.keyboard_latch[6:0]};
            end else if (low <= 8'h1F) begin
                io.kind = IO_DATA;
                io.val  = {stat, 7'd0};
            end else if (low == 8'h20 || low == 8'h30 || low == 8'h33) begin
                io.spk = 1'b1;
            end else if (low >= 8'h50 && low <= 8'h57) begin
                // Text, mixed, page2, hires in address order
                n_state.disp[{1'b0, low[2:1]}] = on;
                io.vid = 1'b1;
            end else if (low >= 8'h58 && low <= 8'h5F) begin
                if (!r_state.io_disable) begin
                    n_state.ann[low[2:1]] = on;
                end
                if (low == 8'h5E) begin
                    n_state.disp[DF_DHIRES] = 1'b1;
                end
                if (low == 8'h5F) begin
                    n_state.disp[DF_DHIRES] = 1'b0;
                end
            end else if ((low >= 8'h61 && low <= 8'h67) || low == 8'h70
                         || low >= 8'h90) begin
                io.kind = IO_EXT;
            end else if (low == 8'h7E || low == 8'h7F) begin
                if (wr) begin
                    n_state.io_disable = on;
                end else begin
                    io.kind = IO_DATA;
                    io.val  = {(on ? r_state.disp[DF_DHIRES] : r_state.io_disable), 7'd0};
                end
            end else if (low >= 8'h80 && low <= 8'h8F) begin
                // Language card control, address bit 2 ignored
                n_state.bank_two = ~low[3];
                n_state.rd_en    = (low[1:0] == 2'd0) || (low[1:0] == 2'd3);
                if (on) begin
                    n_state.wr_en    = r_state.wr_en | r_state.prewrite;
                    n_state.prewrite = ~wr;
                end else begin
                    n_state.wr_en    = 1'b0;
                    n_state.prewrite = 1'b0;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.keyboard_latch <= 8'h00;
            r_state.mm             <= 6'd0;
            r_state.disp           <= 7'b0000001;
            r_state.ann            <= 4'b1100;
            r_state.io_disable     <= 1'b0;
            r_state.bank_two       <= 1'b1;
            r_state.rd_en          <= 1'b0;
            r_state.wr_en          <= 1'b1;
            r_state.prewrite       <= 1'b0;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

    assign o_state     = r_state;
    assign o_io        = io;
    assign o_disp_next = n_state.disp;
    assign o_ann_next  = n_state.ann;

endmodule

`default_nettype wire

FILE: design/bsm_decode.sv
`default_nettype none

module bsm_decode (
    input  wire [1:0]            i_operation,
    input  wire [15:0]           i_address,
    input  wire [7:0]            i_write_data,
    input  wire [7:0]            i_floating_value,
    input  bsm_pkg::t_sw_state   i_state,
    input  bsm_pkg::t_io_result  i_io,
    output bsm_pkg::t_result     o_result
);
    import bsm_pkg::*;

    t_result res;
    logic    wr;
    logic    sel;
    logic    ax;
    logic    s80;
    logic    internal;
    logic    en;
    logic    b2;
    logic    alt;

    assign wr  = (i_operation == OP_WRITE);
    assign s80 = i_state.mm[MM_STORE80];
    assign sel = wr ? i_state.mm[MM_RAMWRT] : i_state.mm[MM_RAMRD];
    assign alt = i_state.mm[MM_ALTZP];
    assign en  = wr ? i_state.wr_en : i_state.rd_en;
    assign b2  = (i_address < LC_HIGH) && i_state.bank_two;

    // Main/aux select for the low 48K
    always_comb begin
        if (i_address[15:9] == 7'd0) begin
            ax = alt;
        end else if (i_address[15:10] == 6'b000001) begin
            ax = s80 ? i_state.disp[DF_PAGE2] : sel;
        end else if (i_address[15:13] == 3'b001) begin
            ax = s80 ? (i_state.disp[DF_PAGE2] && i_state.disp[DF_HIRES]) : sel;
        end else begin
            ax = sel;
        end
    end

    // Slot ROM source
    always_comb begin
        if ((i_address[15:8] == 8'hC3) || (i_address[11] == 1'b1)) begin
            internal = i_state.mm[MM_INTCXROM] || !i_state.mm[MM_SLOTC3ROM];
        end else begin
            internal = i_state.mm[MM_INTCXROM];
        end
    end

    // Target and offset mapping
    always_comb begin
        res.target         = TGT_IGNORED;
        res.bank_offset    = 16'h0000;
        res.read_data      = 8'h00;
        res.write_strobe   = 1'b0;
        res.write_value    = 8'h00;
        res.speaker_toggle = i_io.spk;
        res.video_refresh  = i_io.vid;

        if (i_operation == OP_READ || i_operation == OP_WRITE) begin
            if (wr) begin
                res.write_value = i_write_data;
            end
            if (i_address < IO_BASE) begin
                res.target       = ax ? TGT_AUX : TGT_MAIN;
                res.bank_offset  = i_address;
                res.write_strobe = wr;
            end else if (i_address[15:8] == IO_PAGE) begin
                if (i_io.kind == IO_EXT) begin
                    res.target       = TGT_EXT_IO;
                    res.bank_offset  = {8'h00, i_address[7:0]};
                    res.write_strobe = wr;
                end else if (!wr) begin
                    res.target      = (i_io.kind == IO_DATA) ? TGT_DATA : TGT_FLOAT;
                    res.bank_offset = {8'h00, i_address[7:0]};
                    res.read_data   = (i_io.kind == IO_DATA) ? i_io.val : i_floating_value;
                end
            end else if (i_address < EXP_OFF) begin
                if (!wr) begin
                    res.target      = internal ? TGT_ROM : TGT_SLOT_ROM;
                    res.bank_offset = {4'h0, i_address[11:0]};
                end
            end else if (i_address == EXP_OFF) begin
                res.target = TGT_EXP_OFF;
            end else if (en) begin
                if (b2) begin
                    res.target = alt ? TGT_LC_AUX2 : TGT_LC_MAIN2;
                end else begin
                    res.target = alt ? TGT_LC_AUX1 : TGT_LC_MAIN1;
                end
                res.bank_offset  = i_address - LC_BASE;
                res.write_strobe = wr;
            end else if (!wr) begin
                res.target      = TGT_ROM;
                res.bank_offset = i_address - IO_BASE;
            end
        end
    end

    assign o_result = res;

endmodule

`default_nettype wire
